### rtl/core/tlhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag-length header parser package
// Field widths and the result record shared by the parser modules.
// ----------------------------------------------------------------------------
package tlhp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TAG_W  = 7;
  localparam int unsigned SIZE_W = 28;
  localparam int unsigned HLEN_W = 3;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] payload_size;
    logic              long_form;
    logic [HLEN_W-1:0] header_length;
    logic              status;
  } tlhp_result_t;

endpackage

### rtl/core/tlhp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Holds one stream byte until the parser consumes it.
// ----------------------------------------------------------------------------
module tlhp_in_reg
  import tlhp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              consume_i,
  output logic              vld_o,
  output logic [BYTE_W-1:0] byte_o
);

  logic              vld_d, vld_q;
  logic [BYTE_W-1:0] byte_q;
  logic              accept;

  // The register frees up in the same cycle that its byte is consumed.
  assign in_stall_o = vld_q && !consume_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (consume_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

### rtl/core/tlhp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header parser
// Header state and the decode of one byte into the next state and a result.
// ----------------------------------------------------------------------------
module tlhp_parse
  import tlhp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic              emit_o,
  output tlhp_result_t      res_o
);

  localparam logic [1:0] PH_TAG  = 2'd0;
  localparam logic [1:0] PH_LEN0 = 2'd1;
  localparam logic [1:0] PH_LENN = 2'd2;

  logic [1:0]        phase_d, phase_q;
  logic [1:0]        left_d, left_q;
  logic [SIZE_W-1:0] acc_d, acc_q;
  logic [TAG_W-1:0]  held_d, held_q;
  logic [HLEN_W-1:0] hcnt_d, hcnt_q;

  logic [SIZE_W-1:0] acc_shift;
  logic [HLEN_W-1:0] hcnt_inc;
  logic [1:0]        left_dec;
  logic [1:0]        code;

  assign acc_shift = {acc_q[SIZE_W-BYTE_W-1:0], byte_i};
  assign hcnt_inc  = hcnt_q + HLEN_W'(1);
  assign left_dec  = left_q - 2'd1;
  assign code      = byte_i[6:5];

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    acc_d   = acc_q;
    held_d  = held_q;
    hcnt_d  = hcnt_q;
    emit_o  = 1'b0;
    res_o   = '0;
    case (phase_q)
      PH_LEN0: begin
        hcnt_d = HLEN_W'(2);
        res_o.tag           = held_q;
        res_o.long_form     = 1'b1;
        res_o.header_length = HLEN_W'(2);
        if (!byte_i[7]) begin
          phase_d            = PH_TAG;
          emit_o             = 1'b1;
          res_o.payload_size = SIZE_W'(byte_i[6:0]);
        end else if (!byte_i[6]) begin
          acc_d   = SIZE_W'(byte_i[5:0]);
          left_d  = 2'd1;
          phase_d = PH_LENN;
        end else if (!byte_i[5]) begin
          acc_d   = SIZE_W'(byte_i[4:0]);
          left_d  = 2'd2;
          phase_d = PH_LENN;
        end else if (!byte_i[4]) begin
          acc_d   = SIZE_W'(byte_i[3:0]);
          left_d  = 2'd3;
          phase_d = PH_LENN;
        end else begin
          // Prefix 1111 is not a legal length; report it and resync on a tag.
          phase_d      = PH_TAG;
          acc_d        = '0;
          left_d       = 2'd0;
          emit_o       = 1'b1;
          res_o.status = 1'b1;
        end
      end
      PH_LENN: begin
        acc_d  = acc_shift;
        hcnt_d = hcnt_inc;
        left_d = left_dec;
        res_o.tag           = held_q;
        res_o.payload_size  = acc_shift;
        res_o.long_form     = 1'b1;
        res_o.header_length = hcnt_inc;
        if (left_dec == 2'd0) begin
          phase_d = PH_TAG;
          emit_o  = 1'b1;
        end
      end
      default: begin
        hcnt_d = HLEN_W'(1);
        if (!byte_i[7]) begin
          phase_d             = PH_TAG;
          emit_o              = 1'b1;
          res_o.tag           = TAG_W'(byte_i[4:0]);
          res_o.header_length = HLEN_W'(1);
          case (code)
            2'd1:    res_o.payload_size = SIZE_W'(1);
            2'd2:    res_o.payload_size = SIZE_W'(2);
            2'd3:    res_o.payload_size = SIZE_W'(4);
            default: res_o.payload_size = '0;
          endcase
        end else begin
          held_d  = byte_i[6:0];
          acc_d   = '0;
          left_d  = 2'd0;
          phase_d = PH_LEN0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      left_q  <= 2'd0;
      acc_q   <= '0;
      held_q  <= '0;
      hcnt_q  <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      held_q  <= held_d;
      hcnt_q  <= hcnt_d;
    end
  end

  // While more length bytes are due, the down counter is never at zero.
  a_lenn_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LENN |-> left_q != 2'd0)
    else $error("length phase with no bytes left");

  a_short_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && !res_o.long_form |-> res_o.header_length == HLEN_W'(1) && !res_o.status)
    else $error("short token with bad header length or status");

  a_bad_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && res_o.status |-> res_o.payload_size == '0
                               && res_o.header_length == HLEN_W'(2))
    else $error("bad prefix result malformed");

  a_hlen_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> res_o.header_length != HLEN_W'(0) && res_o.header_length <= HLEN_W'(5))
    else $error("header length out of range");

  a_len0_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && phase_q == PH_LEN0 |=> hcnt_q == HLEN_W'(2))
    else $error("header count wrong after first length byte");

endmodule

### rtl/core/tlhp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tlhp_out_reg
  import tlhp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  tlhp_result_t res_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output tlhp_result_t res_o
);

  logic         vld_d, vld_q;
  tlhp_result_t res_q;

  // A new result may enter when the slot is empty or is being drained now.
  assign ready_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (ready_o) begin
      vld_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

### rtl/core/tag_length_header_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag-length header parser
// Recognizes short and long tag headers, one input byte a cycle if unstalled.
// ----------------------------------------------------------------------------
// Path: the byte that completes a header waits in the input register; its
//   result is then loaded into the result register, which holds it until
//   taken. A stall on the result side can hold the byte in between.
// Throughput: one byte per cycle unless the result side stalls.
// Reset: rst_ni clears both valid bits and returns the parser to expecting
//   a tag byte.
module tag_length_header_parser_top
  import tlhp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TAG_W-1:0]  out_tag_o,
  output logic [SIZE_W-1:0] out_payload_size_o,
  output logic              out_long_form_o,
  output logic [HLEN_W-1:0] out_header_length_o,
  output logic              out_status_o
);

  logic              byte_vld;
  logic [BYTE_W-1:0] byte_val;
  logic              out_ready;
  logic              advance;
  logic              emit;
  tlhp_result_t      res;
  tlhp_result_t      res_out;

  assign advance = byte_vld && out_ready;

  tlhp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .consume_i  (advance),
    .vld_o      (byte_vld),
    .byte_o     (byte_val)
  );

  tlhp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (byte_val),
    .emit_o    (emit),
    .res_o     (res)
  );

  tlhp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && emit),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign out_tag_o           = res_out.tag;
  assign out_payload_size_o  = res_out.payload_size;
  assign out_long_form_o     = res_out.long_form;
  assign out_header_length_o = res_out.header_length;
  assign out_status_o        = res_out.status;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the tag-length header parser
// Feeds byte streams of short tokens, long tokens with one to four length
// bytes, bad length prefixes and raw noise, with random gaps on the byte side
// and random stalls on the result side. Every accepted byte runs through a
// behavioral parser in the bench, and each result from the block is compared
// field by field with the oldest predicted header.
// ----------------------------------------------------------------------------
module tb_top;
  import tlhp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned RANDOM_BYTES   = 310;

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_BAD_PREFIX = 1'b1;

  typedef enum logic [1:0] {
    PH_TAG       = 2'd0,
    PH_LEN_FIRST = 2'd1,
    PH_LEN_MORE  = 2'd2
  } parse_phase_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [BYTE_W-1:0] in_byte_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [TAG_W-1:0]  out_tag_o;
  logic [SIZE_W-1:0] out_payload_size_o;
  logic              out_long_form_o;
  logic [HLEN_W-1:0] out_header_length_o;
  logic              out_status_o;

  tag_length_header_parser_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_byte_i          (in_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_tag_o          (out_tag_o),
    .out_payload_size_o (out_payload_size_o),
    .out_long_form_o    (out_long_form_o),
    .out_header_length_o(out_header_length_o),
    .out_status_o       (out_status_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow state of the header parser.
  parse_phase_e      hdr_phase = PH_TAG;
  logic [1:0]        len_bytes_left = '0;
  logic [SIZE_W-1:0] len_acc = '0;
  logic [TAG_W-1:0]  held_tag = '0;
  logic [HLEN_W-1:0] hdr_bytes = '0;

  tlhp_result_t expected_headers[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles = 0;

  // Advances the shadow parser by one byte; returns 1 when a header completes.
  function automatic bit predict_header(input logic [BYTE_W-1:0] b,
                                        output tlhp_result_t r);
    r = '0;
    r.tag = held_tag;
    r.long_form = 1'b1;
    r.status = STATUS_OK;
    case (hdr_phase)
      PH_LEN_FIRST: begin
        hdr_bytes = 3'd2;
        r.header_length = 3'd2;
        hdr_phase = PH_LEN_MORE;
        casez (b)
          8'b0???????: begin
            hdr_phase = PH_TAG;
            r.payload_size = SIZE_W'(b[6:0]);
            return 1'b1;
          end
          8'b10??????: begin
            len_acc = SIZE_W'(b[5:0]);
            len_bytes_left = 2'd1;
          end
          8'b110?????: begin
            len_acc = SIZE_W'(b[4:0]);
            len_bytes_left = 2'd2;
          end
          8'b1110????: begin
            len_acc = SIZE_W'(b[3:0]);
            len_bytes_left = 2'd3;
          end
          default: begin
            // A 1111 prefix ends the header with an error and no size.
            hdr_phase = PH_TAG;
            len_acc = '0;
            len_bytes_left = '0;
            r.payload_size = '0;
            r.status = STATUS_BAD_PREFIX;
            return 1'b1;
          end
        endcase
        return 1'b0;
      end
      PH_LEN_MORE: begin
        len_acc = {len_acc[SIZE_W-9:0], b};
        hdr_bytes = hdr_bytes + 3'd1;
        len_bytes_left = len_bytes_left - 2'd1;
        if (len_bytes_left != 2'd0) begin
          return 1'b0;
        end
        hdr_phase = PH_TAG;
        r.payload_size = len_acc;
        r.header_length = hdr_bytes;
        return 1'b1;
      end
      default: begin
        hdr_bytes = 3'd1;
        if (b[7]) begin
          held_tag = b[6:0];
          len_acc = '0;
          len_bytes_left = '0;
          hdr_phase = PH_LEN_FIRST;
          return 1'b0;
        end
        hdr_phase = PH_TAG;
        r.tag = TAG_W'(b[4:0]);
        r.payload_size = (b[6:5] == 2'd0) ? '0 : SIZE_W'(1) << (b[6:5] - 2'd1);
        r.long_form = 1'b0;
        r.header_length = 3'd1;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    tlhp_result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_byte_i = b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (predict_header(b, r)) begin
      expected_headers.push_back(r);
    end
    bytes_sent++;
  endtask

  task automatic send_stream(input logic [BYTE_W-1:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // Result side: random stalls, driven at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    tlhp_result_t exp_hdr;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_headers.size() == 0) begin
          $error("unexpected header result: tag %0d size %0d", out_tag_o,
                 out_payload_size_o);
          mismatch_count++;
        end else begin
          exp_hdr = expected_headers.pop_front();
          if (out_tag_o !== exp_hdr.tag) begin
            $error("tag: expected %0d, got %0d", exp_hdr.tag, out_tag_o);
            mismatch_count++;
          end
          if (out_payload_size_o !== exp_hdr.payload_size) begin
            $error("payload_size: expected %0d, got %0d", exp_hdr.payload_size,
                   out_payload_size_o);
            mismatch_count++;
          end
          if (out_long_form_o !== exp_hdr.long_form) begin
            $error("long_form: expected %0d, got %0d", exp_hdr.long_form,
                   out_long_form_o);
            mismatch_count++;
          end
          if (out_header_length_o !== exp_hdr.header_length) begin
            $error("header_length: expected %0d, got %0d", exp_hdr.header_length,
                   out_header_length_o);
            mismatch_count++;
          end
          if (out_status_o !== exp_hdr.status) begin
            $error("status: expected %0d, got %0d", exp_hdr.status, out_status_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Short tokens with every size code and the lowest and highest tags.
  task automatic test_short_tokens();
    send_stream('{8'h00, 8'h1F, 8'h20, 8'h4A, 8'h7F, 8'h60});
  endtask

  // Long tokens whose length fits in one byte, at both ends of the range.
  task automatic test_long_single_length();
    send_stream('{8'h80, 8'h00, 8'hFF, 8'h7F});
  endtask

  // Two-, three- and four-byte lengths, up to the largest 28-bit size.
  task automatic test_long_multi_length();
    send_stream('{8'h85, 8'hBF, 8'hFF, 8'h81, 8'hC0, 8'h00, 8'h00,
                  8'h82, 8'hEF, 8'hFF, 8'hFF, 8'hFF});
  endtask

  // A 1111 prefix must be consumed, so the next byte is a fresh tag.
  task automatic test_bad_prefix();
    send_stream('{8'h83, 8'hF0, 8'h84, 8'hFF, 8'h25});
  endtask

  // Mostly well-formed headers with random content, some bad prefixes and noise.
  task automatic test_random_headers(input int unsigned n_bytes);
    int unsigned        stop_at;
    int unsigned        kind;
    int unsigned        n_len;
    logic [BYTE_W-1:0]  first_len;
    logic [BYTE_W-1:0]  bytes[$];
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(99);
      bytes.delete();
      if (kind < 35) begin
        bytes.push_back(BYTE_W'($urandom_range(127)));
      end else if (kind < 85) begin
        bytes.push_back(8'h80 | BYTE_W'($urandom_range(127)));
        n_len = $urandom_range(1, 4);
        first_len = BYTE_W'($urandom_range(255));
        case (n_len)
          1: first_len[7] = 1'b0;
          2: first_len[7:6] = 2'b10;
          3: first_len[7:5] = 3'b110;
          default: first_len[7:4] = 4'b1110;
        endcase
        bytes.push_back(first_len);
        repeat (n_len - 1) bytes.push_back(BYTE_W'($urandom_range(255)));
      end else if (kind < 95) begin
        bytes.push_back(8'h80 | BYTE_W'($urandom_range(127)));
        bytes.push_back(8'hF0 | BYTE_W'($urandom_range(15)));
      end else begin
        bytes.push_back(BYTE_W'($urandom_range(255)));
      end
      send_stream(bytes);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 20;
    recv_stall_pct = 60;
    test_short_tokens();
    test_long_single_length();
    test_long_multi_length();
    test_bad_prefix();
    test_random_headers(RANDOM_BYTES);

    send_idle_pct = 60;
    recv_stall_pct = 20;
    test_random_headers(RANDOM_BYTES);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_headers(RANDOM_BYTES);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_headers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
